// ===== rtl/mtu_pkg.sv =====
`timescale 1ns / 1ps

package mtu_pkg;

  // Command codes carried in the action field.
  localparam logic [2:0] ACT_IDENTITY    = 3'd0;
  localparam logic [2:0] ACT_TRANSLATE   = 3'd1;
  localparam logic [2:0] ACT_SCALE       = 3'd2;
  localparam logic [2:0] ACT_ROTATE      = 3'd3;
  localparam logic [2:0] ACT_FRUSTUM     = 3'd4;
  localparam logic [2:0] ACT_PERSPECTIVE = 3'd5;
  localparam logic [2:0] ACT_ORTHO       = 3'd6;
  localparam logic [2:0] ACT_SELECT      = 3'd7;

  // Rotation axis codes.
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Width of a saturating intermediate and of a raw angle before reduction.
  localparam int SAT_W = 66;
  localparam int ANG_W = 56;

  // CORDIC datapath width, Q2.30 with headroom.
  localparam int ZW = 36;
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [31:0]   PI360_Q30   = 32'sd9370165;

  // Matrix store: two matrices, each with two halves of 16 entries.
  localparam int MEM_DEPTH = 64;
  localparam int MEM_AW    = 6;

  typedef struct packed {
    logic                     wr_en;
    logic [MEM_AW-1:0]        wr_addr;
    logic signed [31:0]       wr_data;
    logic                     clr_en;
    logic                     clr_mat;
  } store_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(Q_MAX);
    lo = SAT_W'(Q_MIN);
    if (v > hi) begin
      return Q_MAX;
    end else if (v < lo) begin
      return Q_MIN;
    end else begin
      return v[31:0];
    end
  endfunction

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048576;
      5'd11: r = 36'sd524288;
      5'd12: r = 36'sd262144;
      5'd13: r = 36'sd131072;
      5'd14: r = 36'sd65536;
      5'd15: r = 36'sd32768;
      5'd16: r = 36'sd16384;
      5'd17: r = 36'sd8192;
      5'd18: r = 36'sd4096;
      5'd19: r = 36'sd2048;
      5'd20: r = 36'sd1024;
      5'd21: r = 36'sd512;
      5'd22: r = 36'sd256;
      5'd23: r = 36'sd128;
      5'd24: r = 36'sd64;
      5'd25: r = 36'sd32;
      5'd26: r = 36'sd16;
      5'd27: r = 36'sd8;
      5'd28: r = 36'sd4;
      5'd29: r = 36'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mtu_intf.sv =====
`timescale 1ns / 1ps

interface mtu_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [31:0] op_c;
  logic signed [31:0] op_d;
  logic signed [31:0] op_e;
  logic signed [31:0] op_f;
  logic [1:0]         axis_sel;
  logic               matrix_sel;

  modport source (output valid, action, op_a, op_b, op_c, op_d, op_e, op_f,
                  axis_sel, matrix_sel, input ready);
  modport sink (input valid, action, op_a, op_b, op_c, op_d, op_e, op_f,
                axis_sel, matrix_sel, output ready);
endinterface

interface mtu_elem_if;
  logic               valid;
  logic               ready;
  logic               which_matrix;
  logic [1:0]         elem_row;
  logic [1:0]         elem_col;
  logic signed [31:0] elem_value;
  logic               last;

  modport source (output valid, which_matrix, elem_row, elem_col, elem_value, last,
                  input ready);
  modport sink (input valid, which_matrix, elem_row, elem_col, elem_value, last,
                output ready);
endinterface

// ===== rtl/mtu_store.sv =====
`timescale 1ns / 1ps

module mtu_store import mtu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  store_req_t         req,
  input  logic [MEM_AW-1:0]  rd_addr,
  output logic signed [31:0] rd_data
);

  localparam logic signed [31:0] ONE_Q = 32'(64'sd1 << FRAC_BITS);

  logic signed [31:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  vld;
  logic                  diag;

  // An entry never written since reset or since an identity load reads as identity.
  assign diag = (rd_addr[3:2] == rd_addr[1:0]);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (vld[rd_addr]) begin
      rd_data <= mem[rd_addr];
    end else begin
      rd_data <= diag ? ONE_Q : 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (req.clr_en) begin
        for (int e = 0; e < MEM_DEPTH / 2; e++) begin
          vld[{req.clr_mat, 5'(e)}] <= 1'b0;
        end
      end
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mtu_div.sv =====
`timescale 1ns / 1ps

module mtu_div import mtu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] dvd;
  logic [NW-1:0] qr;
  logic [31:0]   rem;
  logic [31:0]   dsr;
  logic          neg;
  logic [32:0]   un;
  logic [32:0]   ud;
  logic [32:0]   remsh;
  logic          ge;
  logic          big;
  logic          over_pos;
  logic          over_neg;

  assign un = num[31] ? -{num[31], num} : {num[31], num};
  assign ud = den[31] ? -{den[31], den} : {den[31], den};
  assign remsh = {rem, dvd[NW-1]};
  assign ge = (remsh >= {1'b0, dsr});
  assign big = |qr[NW-1:32];
  assign over_pos = big | qr[31];
  assign over_neg = big | (qr[31] & (|qr[30:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 32'sd0) begin
          quo  <= (num >= 32'sd0) ? Q_MAX : Q_MIN;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CW'(NW);
          dvd  <= {un[31:0], {FRAC_BITS{1'b0}}};
          dsr  <= ud[31:0];
          rem  <= '0;
          qr   <= '0;
          neg  <= num[31] ^ den[31];
        end
      end else if (busy) begin
        if (cnt != '0) begin
          rem <= ge ? 32'(remsh - {1'b0, dsr}) : remsh[31:0];
          dvd <= {dvd[NW-2:0], 1'b0};
          qr  <= {qr[NW-2:0], ge};
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            quo <= over_neg ? Q_MIN : -qr[31:0];
          end else begin
            quo <= over_pos ? Q_MAX : qr[31:0];
          end
        end
      end
    end
  end

endmodule

// ===== rtl/mtu_cordic.sv =====
`timescale 1ns / 1ps

module mtu_cordic import mtu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    done,
  output logic signed [31:0]      sin_q,
  output logic signed [31:0]      cos_q
);

  localparam int SH  = ANG_W - 33;
  localparam int PSH = 30 - FRAC_BITS;
  localparam logic [ANG_W-1:0] TWO_PI_W = ANG_W'(TWO_PI_Q30);

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_RED  = 5'b00010,
    C_FIX  = 5'b00100,
    C_ROT  = 5'b01000,
    C_OUT  = 5'b10000
  } cstate_t;

  cstate_t              state;
  logic [ANG_W-1:0]     mag;
  logic                 sgn;
  logic [4:0]           s;
  logic [4:0]           it;
  logic signed [ZW-1:0] x;
  logic signed [ZW-1:0] y;
  logic signed [ZW-1:0] z;
  logic                 flip;
  logic [ANG_W-1:0]     m_sh;
  logic signed [ZW-1:0] r;
  logic signed [ZW-1:0] z0;
  logic signed [ZW-1:0] z1;
  logic signed [ZW-1:0] zr;
  logic                 fl;
  logic signed [ZW-1:0] sx;
  logic signed [ZW-1:0] sy;
  logic signed [ZW-1:0] xf;
  logic signed [ZW-1:0] ys;
  logic signed [ZW-1:0] xs;

  assign m_sh = TWO_PI_W << s;
  assign r = signed'(mag[ZW-1:0]);
  assign sx = x >>> it;
  assign sy = y >>> it;
  assign xf = flip ? -x : x;
  assign ys = y >>> PSH;
  assign xs = xf >>> PSH;

  // Map the reduced angle into (-pi, pi], then fold into [-pi/2, pi/2].
  always_comb begin
    z0 = (sgn && (r != '0)) ? (TWO_PI_Q30 - r) : r;
    z1 = (z0 > PI_Q30) ? (z0 - TWO_PI_Q30) : z0;
    zr = z1;
    fl = 1'b0;
    if (z1 > HALF_PI_Q30) begin
      zr = PI_Q30 - z1;
      fl = 1'b1;
    end else if (z1 < -HALF_PI_Q30) begin
      zr = -PI_Q30 - z1;
      fl = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            mag   <= angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
            sgn   <= angle[ANG_W-1];
            s     <= 5'(SH);
            state <= C_RED;
          end
        end
        C_RED: begin
          if (mag >= m_sh) begin
            mag <= mag - m_sh;
          end
          if (s == '0) begin
            state <= C_FIX;
          end else begin
            s <= s - 1'b1;
          end
        end
        C_FIX: begin
          z     <= zr;
          flip  <= fl;
          x     <= GAIN_Q30;
          y     <= '0;
          it    <= '0;
          state <= C_ROT;
        end
        C_ROT: begin
          if (z >= 0) begin
            x <= x - sy;
            y <= y + sx;
            z <= z - atan_q30(it);
          end else begin
            x <= x + sy;
            y <= y - sx;
            z <= z + atan_q30(it);
          end
          if (it == 5'(CORDIC_STEPS - 1)) begin
            state <= C_OUT;
          end else begin
            it <= it + 1'b1;
          end
        end
        C_OUT: begin
          sin_q <= ys[31:0];
          cos_q <= xs[31:0];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/matrix_transform_unit_top.sv =====
`timescale 1ns / 1ps

// Matrix transform unit. The block holds a model-view and a projection 4x4 matrix of
// signed fixed-point elements with FRAC_BITS fraction bits; after reset both are identity
// and the projection matrix is active. Each command item on the cmd channel selects the
// active matrix, loads identity into it, or premultiplies it by a translate, scale, axis
// rotation, frustum, perspective or ortho matrix, and then the block sends the sixteen
// elements of the active matrix in row order on the elem channel, with last set on the
// sixteenth. One command is worked at a time and cmd.ready is high only between commands.
// Identity and select only run the output, which reads each element from the registered
// matrix memory and issues a new read only once the last one has been taken into the
// output register. Translate, scale and rotate add a 64-step multiply-accumulate pass
// over the memory; rotate adds angle reduction and CORDIC. Frustum and ortho add six
// serial divisions, and perspective adds the CORDIC, one more division and four
// multiplies. Results past the 32-bit range saturate, and a division by zero returns
// the largest magnitude with the sign of the numerator.

module matrix_transform_unit_top import mtu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mtu_cmd_if.sink    cmd,
  mtu_elem_if.source elem
);

  localparam int PSH   = 30 - FRAC_BITS;
  localparam int ACC_W = 66 - FRAC_BITS;
  localparam logic signed [31:0] ONE_Q   = 32'(64'sd1 << FRAC_BITS);
  localparam logic signed [31:0] TWO_Q   = 32'(64'sd2 << FRAC_BITS);
  localparam logic signed [31:0] M_TWO_Q = -TWO_Q;
  localparam logic signed [31:0] M_ONE_Q = -ONE_Q;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_ANG  = 10'b00_0000_0010,
    S_TRIG = 10'b00_0000_0100,
    S_TAN  = 10'b00_0000_1000,
    S_YMAX = 10'b00_0001_0000,
    S_XMUL = 10'b00_0010_0000,
    S_FN   = 10'b00_0100_0000,
    S_DIV  = 10'b00_1000_0000,
    S_MAC  = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Control state.
  logic       act_sel;
  logic [1:0] cur_half;
  logic       ph;
  logic [2:0] jcnt;
  logic [6:0] mc;
  logic       v1;
  logic       v2;
  logic [4:0] ecnt;
  logic       pend;
  logic       ov;

  // Command operands and working values.
  logic [2:0]              act;
  logic [1:0]              axis;
  logic signed [31:0]      oa, ob, oc, od, oe, of;
  logic signed [ANG_W-1:0] ang;
  logic signed [31:0]      tmat [16];
  logic signed [31:0]      tn;
  logic signed [31:0]      ymax;
  logic signed [31:0]      fnq;

  // Multiply-accumulate pipeline.
  logic signed [31:0]      t_d;
  logic [3:0]              tag1_ij, tag2_ij;
  logic [1:0]              tag1_k, tag2_k;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      prod;
  logic signed [63:0]      prod_sh;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [31:0]      mulq_res;
  logic signed [31:0]      ymin;

  // Output stage.
  logic [3:0]         pidx;
  logic               o_mat;
  logic [1:0]         o_row, o_col;
  logic signed [31:0] o_val;
  logic               o_last;

  // Memory and arithmetic units.
  store_req_t         req;
  logic [MEM_AW-1:0]  rd_addr;
  logic signed [31:0] rd_data;
  logic               dv_start, dv_done;
  logic signed [31:0] dv_num, dv_den, dv_quo;
  logic               cr_start, cr_done;
  logic signed [31:0] sn, cs;

  // Division job operands for frustum and ortho.
  logic signed [31:0] rl, tb, fnd, rpl, m_rpl, tpb, m_tpb, n2, m_fpn, m_fn2;
  logic signed [31:0] job_num, job_den;
  logic [3:0]         job_dst;

  logic fire;
  logic iss;

  assign fire = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);

  assign prod_sh  = prod >>> FRAC_BITS;
  assign term     = prod_sh[ACC_W-1:0];
  assign acc_sum  = acc + term;
  assign mulq_res = sat32(SAT_W'(prod_sh));
  assign ymin     = sat32(-SAT_W'(ymax));

  // Frustum and ortho terms, all saturated to 32 bits. Operands stand as
  // left, right, bottom, top, near, far in oa through of.
  assign rl    = sat32(SAT_W'(ob) - SAT_W'(oa));
  assign tb    = sat32(SAT_W'(od) - SAT_W'(oc));
  assign fnd   = sat32(SAT_W'(of) - SAT_W'(oe));
  assign rpl   = sat32(SAT_W'(ob) + SAT_W'(oa));
  assign m_rpl = sat32(-SAT_W'(ob) - SAT_W'(oa));
  assign tpb   = sat32(SAT_W'(od) + SAT_W'(oc));
  assign m_tpb = sat32(-SAT_W'(od) - SAT_W'(oc));
  assign n2    = sat32(SAT_W'(oe) + SAT_W'(oe));
  assign m_fpn = sat32(-SAT_W'(of) - SAT_W'(oe));
  assign m_fn2 = sat32(-SAT_W'(fnq) - SAT_W'(fnq));

  always_comb begin
    job_num = n2;
    job_den = rl;
    job_dst = 4'd0;
    if (act == ACT_ORTHO) begin
      unique case (jcnt)
        3'd0: begin job_num = TWO_Q;   job_den = rl;  job_dst = 4'd0;  end
        3'd1: begin job_num = m_rpl;   job_den = rl;  job_dst = 4'd3;  end
        3'd2: begin job_num = TWO_Q;   job_den = tb;  job_dst = 4'd5;  end
        3'd3: begin job_num = m_tpb;   job_den = tb;  job_dst = 4'd7;  end
        3'd4: begin job_num = M_TWO_Q; job_den = fnd; job_dst = 4'd10; end
        3'd5: begin job_num = m_fpn;   job_den = fnd; job_dst = 4'd11; end
        default: begin job_num = TWO_Q; job_den = rl; job_dst = 4'd0; end
      endcase
    end else begin
      unique case (jcnt)
        3'd0: begin job_num = n2;    job_den = rl;  job_dst = 4'd0;  end
        3'd1: begin job_num = rpl;   job_den = rl;  job_dst = 4'd2;  end
        3'd2: begin job_num = n2;    job_den = tb;  job_dst = 4'd5;  end
        3'd3: begin job_num = tpb;   job_den = tb;  job_dst = 4'd6;  end
        3'd4: begin job_num = m_fpn; job_den = fnd; job_dst = 4'd10; end
        3'd5: begin job_num = m_fn2; job_den = fnd; job_dst = 4'd11; end
        default: begin job_num = n2; job_den = rl; job_dst = 4'd0; end
      endcase
    end
  end

  // The tangent for perspective shares the divider with the frustum terms.
  assign dv_num   = (state == S_TAN) ? sn : job_num;
  assign dv_den   = (state == S_TAN) ? cs : job_den;
  assign dv_start = ((state == S_TAN) || (state == S_DIV)) && !ph;
  assign cr_start = (state == S_TRIG) && !ph;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = t_d;
    mul_b = rd_data;
    unique case (state)
      S_ANG: begin
        mul_a = oa;
        mul_b = PI360_Q30;
      end
      S_YMAX: begin
        mul_a = oc;
        mul_b = tn;
      end
      S_XMUL: begin
        mul_a = jcnt[0] ? ymax : ymin;
        mul_b = ob;
      end
      S_FN: begin
        mul_a = of;
        mul_b = oe;
      end
      default: begin
        mul_a = t_d;
        mul_b = rd_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // The product pass reads the current half of the active matrix and writes
  // the other half; the halves swap when the pass has drained.
  assign iss = (state == S_EMIT) && !pend && !ecnt[4] && (!ov || elem.ready);

  always_comb begin
    if (state == S_MAC) begin
      rd_addr = {act_sel, cur_half[act_sel], mc[1:0], mc[3:2]};
    end else begin
      rd_addr = {act_sel, cur_half[act_sel], ecnt[3:0]};
    end
    req.wr_en   = v2 && (tag2_k == 2'd3);
    req.wr_addr = {act_sel, ~cur_half[act_sel], tag2_ij};
    req.wr_data = sat32(SAT_W'(acc_sum));
    req.clr_en  = fire && (cmd.action == ACT_IDENTITY);
    req.clr_mat = act_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      act_sel  <= 1'b1;
      cur_half <= '0;
      ph       <= 1'b0;
      jcnt     <= '0;
      mc       <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      ecnt     <= '0;
      pend     <= 1'b0;
      ov       <= 1'b0;
    end else begin
      v1      <= (state == S_MAC) && !mc[6];
      v2      <= v1;
      tag2_ij <= tag1_ij;
      tag2_k  <= tag1_k;

      if (v2) begin
        if (tag2_k == 2'd0) begin
          acc <= term;
        end else begin
          acc <= acc_sum;
        end
      end

      if (pend) begin
        ov <= 1'b1;
      end else if (elem.ready) begin
        ov <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (fire) begin
            act  <= cmd.action;
            axis <= cmd.axis_sel;
            oa   <= cmd.op_a;
            ob   <= cmd.op_b;
            oc   <= cmd.op_c;
            od   <= cmd.op_d;
            oe   <= cmd.op_e;
            of   <= cmd.op_f;
            ang  <= ANG_W'(cmd.op_a) <<< PSH;
            ph   <= 1'b0;
            jcnt <= '0;
            mc   <= '0;
            ecnt <= '0;
            for (int e = 0; e < 16; e++) begin
              tmat[e] <= (e % 5 == 0) ? ONE_Q : 32'sd0;
            end
            unique case (cmd.action)
              ACT_IDENTITY: state <= S_EMIT;
              ACT_TRANSLATE: begin
                tmat[3]  <= cmd.op_a;
                tmat[7]  <= cmd.op_b;
                tmat[11] <= cmd.op_c;
                state    <= S_MAC;
              end
              ACT_SCALE: begin
                tmat[0]  <= cmd.op_a;
                tmat[5]  <= cmd.op_b;
                tmat[10] <= cmd.op_c;
                state    <= S_MAC;
              end
              ACT_ROTATE: state <= (cmd.axis_sel == AXIS_NONE) ? S_EMIT : S_TRIG;
              ACT_FRUSTUM, ACT_PERSPECTIVE, ACT_ORTHO: begin
                for (int e = 0; e < 16; e++) begin
                  tmat[e] <= 32'sd0;
                end
                if (cmd.action == ACT_ORTHO) begin
                  tmat[15] <= ONE_Q;
                  state    <= S_DIV;
                end else begin
                  tmat[14] <= M_ONE_Q;
                  state    <= (cmd.action == ACT_FRUSTUM) ? S_FN : S_ANG;
                end
              end
              ACT_SELECT: begin
                act_sel <= cmd.matrix_sel;
                state   <= S_EMIT;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_ANG: begin
          ph <= ~ph;
          if (ph) begin
            ang   <= prod_sh[ANG_W-1:0];
            state <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (cr_done) begin
            ph <= 1'b0;
            if (act == ACT_ROTATE) begin
              unique case (axis)
                AXIS_X: begin
                  tmat[5] <= cs; tmat[6] <= -sn; tmat[9] <= sn; tmat[10] <= cs;
                end
                AXIS_Y: begin
                  tmat[0] <= cs; tmat[2] <= sn; tmat[8] <= -sn; tmat[10] <= cs;
                end
                default: begin
                  tmat[0] <= cs; tmat[1] <= -sn; tmat[4] <= sn; tmat[5] <= cs;
                end
              endcase
              state <= S_MAC;
            end else begin
              state <= S_TAN;
            end
          end
        end
        S_TAN: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (dv_done) begin
            ph    <= 1'b0;
            tn    <= dv_quo;
            state <= S_YMAX;
          end
        end
        S_YMAX: begin
          ph <= ~ph;
          if (ph) begin
            ymax  <= mulq_res;
            jcnt  <= '0;
            state <= S_XMUL;
          end
        end
        S_XMUL: begin
          ph <= ~ph;
          if (ph) begin
            if (!jcnt[0]) begin
              oa   <= mulq_res;
              jcnt <= 3'd1;
            end else begin
              // The perspective volume becomes an ordinary frustum.
              ob    <= mulq_res;
              oc    <= ymin;
              od    <= ymax;
              oe    <= oc;
              of    <= od;
              jcnt  <= '0;
              state <= S_FN;
            end
          end
        end
        S_FN: begin
          ph <= ~ph;
          if (ph) begin
            fnq   <= mulq_res;
            jcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (dv_done) begin
            ph            <= 1'b0;
            tmat[job_dst] <= dv_quo;
            if (jcnt == 3'd5) begin
              state <= S_MAC;
            end else begin
              jcnt <= jcnt + 1'b1;
            end
          end
        end
        S_MAC: begin
          if (!mc[6]) begin
            t_d     <= tmat[{mc[5:4], mc[1:0]}];
            tag1_ij <= {mc[5:4], mc[3:2]};
            tag1_k  <= mc[1:0];
            mc      <= mc + 1'b1;
          end else if (!v1 && !v2) begin
            cur_half[act_sel] <= ~cur_half[act_sel];
            state             <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (iss) begin
            pend <= 1'b1;
            pidx <= ecnt[3:0];
            ecnt <= ecnt + 1'b1;
          end
          if (pend) begin
            pend   <= 1'b0;
            o_mat  <= act_sel;
            o_row  <= pidx[3:2];
            o_col  <= pidx[1:0];
            o_val  <= rd_data;
            o_last <= (pidx == 4'd15);
            if (pidx == 4'd15) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign elem.valid        = ov;
  assign elem.which_matrix = o_mat;
  assign elem.elem_row     = o_row;
  assign elem.elem_col     = o_col;
  assign elem.elem_value   = o_val;
  assign elem.last         = o_last;

  mtu_store #(.FRAC_BITS(FRAC_BITS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mtu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  mtu_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cr_start),
    .angle (ang),
    .done  (cr_done),
    .sin_q (sn),
    .cos_q (cs)
  );

  // A product result must never land in the half that is still being read.
  a_wr_other_half: assert property (@(posedge clk) disable iff (rst)
    req.wr_en |-> (req.wr_addr[4] != cur_half[req.wr_addr[5]]))
    else $error("product write hits the current half of a matrix");

  // An element read is issued only when the output register will be free for it.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(!ov || elem.ready))
    else $error("element read issued while the output register was held");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == S_DIV || state == S_TAN))
    else $error("divider finished outside a division step");

  a_cordic_owner: assert property (@(posedge clk) disable iff (rst)
    cr_done |-> (state == S_TRIG))
    else $error("CORDIC finished outside the trig step");

endmodule

// ===== tb/sv/matrix_transform_unit_checker.sv =====
`timescale 1ns / 1ps

module matrix_transform_unit_checker import mtu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mtu_cmd_if.sink    cmd,
  mtu_elem_if.sink   elem,
  output int         fail_count,
  output int         pending_count,
  output int         elems_seen
);

  typedef struct {
    logic               which;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               last;
  } matrix_elem_t;

  localparam longint QMAXL = 64'sd2147483647;
  localparam longint QMINL = -64'sd2147483648;
  localparam longint ONEQ = longint'(1) << FRAC_BITS;
  localparam longint TWO_PI = 64'sd6746518852;
  localparam longint PI_L = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint GAIN = 64'sd652032874;
  localparam longint PI360 = 64'sd9370165;

  longint modelview_m[16];
  longint projection_m[16];
  logic   proj_active;
  matrix_elem_t expected_elems[$];

  function automatic longint sat(longint v);
    if (v > QMAXL) return QMAXL;
    if (v < QMINL) return QMINL;
    return v;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return sat((a * b) >>> FRAC_BITS);
  endfunction

  function automatic longint divq(longint num, longint den);
    longint un, ud, q;
    if (den == 0) return (num >= 0) ? QMAXL : QMINL;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un << FRAC_BITS) / ud;
    if ((num < 0) != (den < 0)) return (q > 64'sd2147483648) ? QMINL : -q;
    return (q > QMAXL) ? QMAXL : q;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2};
    return tab[i];
  endfunction

  task automatic sin_cos(input longint a30, output longint sn, output longint cs);
    longint z, x, y, nx;
    bit flip;
    z = a30 % TWO_PI;
    x = GAIN;
    y = 0;
    flip = 0;
    if (z < 0) z += TWO_PI;
    if (z > PI_L) z -= TWO_PI;
    if (z > HALF_PI) begin
      z = PI_L - z;
      flip = 1;
    end else if (z < -HALF_PI) begin
      z = -PI_L - z;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_entry(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_entry(i);
      end
      x = nx;
    end
    if (flip) x = -x;
    sn = y >>> (30 - FRAC_BITS);
    cs = x >>> (30 - FRAC_BITS);
  endtask

  function automatic void load_identity(ref longint m[16]);
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ONEQ : 0;
  endfunction

  // New active matrix = t * active, each product floored, each element's sum saturated.
  function automatic void premultiply(const ref longint t[16]);
    longint r[16];
    longint acc;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          if (proj_active) acc += (t[i*4+k] * projection_m[k*4+j]) >>> FRAC_BITS;
          else acc += (t[i*4+k] * modelview_m[k*4+j]) >>> FRAC_BITS;
        end
        r[i*4+j] = sat(acc);
      end
    end
    for (int k = 0; k < 16; k++) begin
      if (proj_active) projection_m[k] = r[k];
      else modelview_m[k] = r[k];
    end
  endfunction

  function automatic void apply_frustum(longint l, longint r, longint b, longint t,
                                        longint n, longint f);
    longint m[16];
    longint n2, rl, tb, fnd;
    foreach (m[k]) m[k] = 0;
    n2 = sat(2 * n);
    rl = sat(r - l);
    tb = sat(t - b);
    fnd = sat(f - n);
    m[0] = divq(n2, rl);
    m[2] = divq(sat(r + l), rl);
    m[5] = divq(n2, tb);
    m[6] = divq(sat(t + b), tb);
    m[10] = divq(sat(-(f + n)), fnd);
    m[11] = divq(sat(-2 * mulq(f, n)), fnd);
    m[14] = -ONEQ;
    premultiply(m);
  endfunction

  function automatic void apply_ortho(longint l, longint r, longint b, longint t,
                                      longint n, longint f);
    longint m[16];
    longint rl, tb, fnd;
    foreach (m[k]) m[k] = 0;
    rl = sat(r - l);
    tb = sat(t - b);
    fnd = sat(f - n);
    m[0] = divq(2 * ONEQ, rl);
    m[3] = divq(sat(-(r + l)), rl);
    m[5] = divq(2 * ONEQ, tb);
    m[7] = divq(sat(-(t + b)), tb);
    m[10] = divq(-2 * ONEQ, fnd);
    m[11] = divq(sat(-(f + n)), fnd);
    m[15] = ONEQ;
    premultiply(m);
  endfunction

  task automatic predict_command();
    longint a, b, c, d, e, f, sn, cs, tn, ymax, ymin;
    longint m[16];
    matrix_elem_t x;
    a = longint'(cmd.op_a);
    b = longint'(cmd.op_b);
    c = longint'(cmd.op_c);
    d = longint'(cmd.op_d);
    e = longint'(cmd.op_e);
    f = longint'(cmd.op_f);
    load_identity(m);
    case (cmd.action)
      ACT_IDENTITY: begin
        if (proj_active) load_identity(projection_m);
        else load_identity(modelview_m);
      end
      ACT_TRANSLATE: begin
        m[3] = a;
        m[7] = b;
        m[11] = c;
        premultiply(m);
      end
      ACT_SCALE: begin
        m[0] = a;
        m[5] = b;
        m[10] = c;
        premultiply(m);
      end
      ACT_ROTATE: begin
        if (cmd.axis_sel != AXIS_NONE) begin
          sin_cos(a * (longint'(1) << (30 - FRAC_BITS)), sn, cs);
          if (cmd.axis_sel == AXIS_X) begin
            m[5] = cs; m[6] = -sn; m[9] = sn; m[10] = cs;
          end else if (cmd.axis_sel == AXIS_Y) begin
            m[0] = cs; m[2] = sn; m[8] = -sn; m[10] = cs;
          end else begin
            m[0] = cs; m[1] = -sn; m[4] = sn; m[5] = cs;
          end
          premultiply(m);
        end
      end
      ACT_FRUSTUM: apply_frustum(a, b, c, d, e, f);
      ACT_PERSPECTIVE: begin
        sin_cos((a * PI360) >>> FRAC_BITS, sn, cs);
        tn = divq(sn, cs);
        ymax = mulq(c, tn);
        ymin = sat(-ymax);
        apply_frustum(mulq(ymin, b), mulq(ymax, b), ymin, ymax, c, d);
      end
      ACT_ORTHO: apply_ortho(a, b, c, d, e, f);
      default: proj_active = cmd.matrix_sel;
    endcase
    for (int k = 0; k < 16; k++) begin
      x.which = proj_active;
      x.row = 2'(k >> 2);
      x.col = 2'(k & 3);
      x.value = proj_active ? 32'(projection_m[k]) : 32'(modelview_m[k]);
      x.last = (k == 15);
      expected_elems.push_back(x);
    end
  endtask

  always @(posedge clk) begin
    matrix_elem_t want;
    if (rst) begin
      load_identity(modelview_m);
      load_identity(projection_m);
      proj_active = 1'b1;
      expected_elems.delete();
      fail_count <= 0;
      elems_seen <= 0;
    end else begin
      if (elem.valid && elem.ready) begin
        elems_seen <= elems_seen + 1;
        if (expected_elems.size() == 0) begin
          $error("element with no expectation: value %0d", elem.elem_value);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_elems.pop_front();
          if (elem.which_matrix !== want.which || elem.elem_row !== want.row ||
              elem.elem_col !== want.col || elem.elem_value !== want.value ||
              elem.last !== want.last) begin
            fail_count <= fail_count + 1;
            if (elem.which_matrix !== want.which)
              $error("which_matrix: expected %0d, got %0d", want.which, elem.which_matrix);
            if (elem.elem_row !== want.row)
              $error("elem_row: expected %0d, got %0d", want.row, elem.elem_row);
            if (elem.elem_col !== want.col)
              $error("elem_col: expected %0d, got %0d", want.col, elem.elem_col);
            if (elem.elem_value !== want.value)
              $error("elem_value: expected %0d, got %0d", want.value, elem.elem_value);
            if (elem.last !== want.last)
              $error("last: expected %0d, got %0d", want.last, elem.last);
          end
        end
      end
      // Commands are predicted after the element check so a same-edge pop stays in order.
      if (cmd.valid && cmd.ready) predict_command();
    end
    pending_count = expected_elems.size();
  end

endmodule

// ===== tb/sv/matrix_transform_unit_top_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the matrix transform unit. The checker beside the
// block keeps its own copy of both matrices and compares every element item.
module matrix_transform_unit_top_tb;
  import mtu_pkg::*;

  localparam int RANDOM_ITEMS = 260;
  localparam int CYCLE_LIMIT = 1200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   elems_seen;
  int   cycle_count = 0;
  int   sent_count = 0;
  int   hold_cycles = 0;
  bit   hold_done = 1'b0;
  bit   stall_enable = 1'b1;

  mtu_cmd_if  cmd();
  mtu_elem_if elem();

  always #6 clk = ~clk;

  matrix_transform_unit_top uut (.clk(clk), .rst(rst), .cmd(cmd), .elem(elem));

  matrix_transform_unit_checker chk (
    .clk(clk), .rst(rst), .cmd(cmd), .elem(elem),
    .fail_count(fail_count), .pending_count(pending_count), .elems_seen(elems_seen)
  );

  // The watchdog ends the run as failed if the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls on its own pattern. A long hold-off early in the random phase
  // lets a command finish computing while its elements cannot drain, so cmd.ready stays low.
  always @(posedge clk) begin
    if (rst) begin
      elem.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      elem.ready <= 1'b0;
    end else if (sent_count == 40 && !hold_done) begin
      hold_cycles <= 2000;
      hold_done <= 1'b1;
      elem.ready <= 1'b0;
    end else if (!stall_enable) begin
      elem.ready <= 1'b1;
    end else begin
      elem.ready <= (cycle_count[6:5] == 2'b11) ? ($urandom_range(0, 3) != 0)
                                                : ($urandom_range(0, 2) == 0);
    end
  end

  // Q16.16 value drawn from a mix of extremes, small numbers and raw random bits.
  function automatic logic signed [31:0] pick_q();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'sd0;
      3, 4: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      5, 6: return 32'($signed($urandom_range(0, 1 << 16)) + (1 << 15));
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [2:0] act,
                           input logic signed [31:0] a, b, c, d, e, f,
                           input logic [1:0] axis, input logic msel);
    cmd.valid <= 1'b1;
    cmd.action <= act;
    cmd.op_a <= a;
    cmd.op_b <= b;
    cmd.op_c <= c;
    cmd.op_d <= d;
    cmd.op_e <= e;
    cmd.op_f <= f;
    cmd.axis_sel <= axis;
    cmd.matrix_sel <= msel;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sent_count++;
  endtask

  // Ends a burst now and then: valid drops for a random gap, and otherwise stays up.
  task automatic burst_gap();
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 40);
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [2:0] act;
    logic signed [31:0] n;
    act = 3'($urandom_range(0, 7));
    n = 32'($urandom_range(1 << 14, 4 << 16));
    if (act == ACT_PERSPECTIVE && $urandom_range(0, 3) != 0)
      // Mostly sensible field of view, aspect, near and far.
      send_item(act, 32'($urandom_range(1, 170) << 16), 32'($urandom_range(1 << 15, 3 << 16)),
                n, n + 32'($urandom_range(1 << 16, 100 << 16)), pick_q(), pick_q(),
                2'($urandom), 1'($urandom));
    else
      send_item(act, pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q(),
                2'($urandom), 1'($urandom));
  endtask

  initial begin
    cmd.valid = 1'b0;
    cmd.action = ACT_IDENTITY;
    cmd.op_a = '0;
    cmd.op_b = '0;
    cmd.op_c = '0;
    cmd.op_d = '0;
    cmd.op_e = '0;
    cmd.op_f = '0;
    cmd.axis_sel = AXIS_X;
    cmd.matrix_sel = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: every command, both matrices, all axis codes, division by zero
    // and operands at the ends of the range.
    send_item(ACT_IDENTITY, 0, 0, 0, 0, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_TRANSLATE, Q_MAX, Q_MIN, 32'sh0001_8000, 0, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_SCALE, Q_MAX, Q_MAX, Q_MIN, 0, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_IDENTITY, 0, 0, 0, 0, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_SCALE, 32'sh0002_0000, 32'shffff_0000, 32'sh0000_8000, 0, 0, 0,
              AXIS_X, 1'b0);
    send_item(ACT_ROTATE, 32'sh0001_921f, 0, 0, 0, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_ROTATE, 32'shfffc_0000, 0, 0, 0, 0, 0, AXIS_Y, 1'b0);
    send_item(ACT_ROTATE, Q_MAX, 0, 0, 0, 0, 0, AXIS_Z, 1'b0);
    send_item(ACT_ROTATE, Q_MIN, 0, 0, 0, 0, 0, AXIS_NONE, 1'b0);
    send_item(ACT_SELECT, 0, 0, 0, 0, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_ROTATE, 32'sh0003_243f, 0, 0, 0, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_SELECT, 0, 0, 0, 0, 0, 0, AXIS_X, 1'b1);
    send_item(ACT_FRUSTUM, 32'shffff_0000, 32'sh0001_0000, 32'shffff_0000, 32'sh0001_0000,
              32'sh0001_0000, 32'sh0064_0000, AXIS_X, 1'b0);
    // Zero-width volumes divide by zero.
    send_item(ACT_FRUSTUM, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 32'sh0002_0000,
              32'sh0002_0000, AXIS_X, 1'b0);
    send_item(ACT_IDENTITY, 0, 0, 0, 0, 0, 0, AXIS_X, 1'b1);
    send_item(ACT_PERSPECTIVE, 32'sh005a_0000, 32'sh0001_5555, 32'sh0000_1999,
              32'sh03e8_0000, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_PERSPECTIVE, 32'sh00b4_0000, Q_MIN, Q_MAX, Q_MIN, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_IDENTITY, 0, 0, 0, 0, 0, 0, AXIS_X, 1'b1);
    send_item(ACT_ORTHO, 32'shfff6_0000, 32'sh000a_0000, 32'shfff6_0000, 32'sh000a_0000,
              32'sh0000_1999, 32'sh0064_0000, AXIS_X, 1'b0);
    send_item(ACT_ORTHO, 0, 0, 0, 0, 0, 0, AXIS_X, 1'b0);
    send_item(ACT_ORTHO, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, AXIS_X, 1'b0);
    send_item(ACT_SELECT, 0, 0, 0, 0, 0, 0, AXIS_X, 1'b0);

    // Random part: bursts with gaps; a stretch with no receiver stall in the middle.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      stall_enable = !(i >= 120 && i < 160);
      // Keep values from pinning at saturation: reset a matrix now and then.
      if ($urandom_range(0, 5) == 0)
        send_item(ACT_IDENTITY, pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q(),
                  2'($urandom), 1'($urandom));
      else
        send_random();
      burst_gap();
    end
    cmd.valid <= 1'b0;

    // Let the checker record the last command before waiting for its elements.
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Ran %0d commands covering all actions, both matrices and saturation cases;",
             sent_count);
    $display("%0d matrix elements were compared.", elems_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
